FILE: sv/uip_pkg.sv
// ----------------------------------------------------------------------------
// uip_pkg
// Shared types and codes for the unordered id pool: the transaction
// payloads, the status codes and the controller to datapath interface.
// ----------------------------------------------------------------------------
package uip_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ADDR_ZERO  = 3'd0,
    ADDR_LAST  = 3'd1,
    ADDR_SCAN  = 3'd2,
    ADDR_COUNT = 3'd3,
    ADDR_HIT   = 3'd4
  } addr_sel_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] id_value;
  } uip_req_t;

  typedef struct packed {
    logic [31:0] popped_value;
    status_e     status;
    logic [6:0]  entry_count;
  } uip_rsp_t;

  typedef struct packed {
    logic      ld_in;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_e addr_sel;
    logic      wr_from_rdata;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      scan_clr;
    logic      scan_inc;
    logic      hit_ld;
    logic      val_ld;
    logic      res_ld;
    logic      res_val;
    status_e   res_status;
  } uip_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic scan_end;
  } uip_sts_t;

endpackage

FILE: sv/unordered_id_pool_core.sv
// ----------------------------------------------------------------------------
// unordered_id_pool_core
// Unordered pool of 32-bit ids with add, pop front and remove by value.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears on rsp_o for exactly one cycle with done_o high, and the receiver
// cannot stall it. An add, a rejected operation or the unused code gives its
// result in the cycle after start and never raises busy. A pop front
// reads the front entry, then moves the last entry into its slot. A remove
// reads one held entry per cycle through the single memory port until it matches or ends.
module unordered_id_pool_core import uip_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  uip_req_t req_i,
  output uip_rsp_t rsp_o,
  output logic     done_o
);

  uip_cmd_t cmd;
  uip_sts_t sts;

  uip_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (req_i.func),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  uip_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .id_i   (req_i.id_value),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

FILE: sv/uip_ctrl.sv
// ----------------------------------------------------------------------------
// uip_ctrl
// Controller for the unordered id pool. Sequences the single memory port
// through append, pop front and search-and-replace transactions.
// ----------------------------------------------------------------------------
module uip_ctrl import uip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic [1:0] func_i,
  input  uip_sts_t sts_i,
  output uip_cmd_t cmd_o,
  output logic     busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_POP_L = 6'b000010,
    S_POP_W = 6'b000100,
    S_SCAN  = 6'b001000,
    S_RM_L  = 6'b010000,
    S_RM_W  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   cmp_vld_q, cmp_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmp_vld_d = 1'b0;
    cmd_o     = '0;
    cmd_o.addr_sel   = ADDR_ZERO;
    cmd_o.res_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.ld_in    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          case (func_i)
            FUNC_ADD: begin
              cmd_o.res_ld = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.addr_sel = ADDR_COUNT;
                cmd_o.cnt_inc  = 1'b1;
              end
            end
            FUNC_POP: begin
              if (sts_i.empty) begin
                cmd_o.res_ld     = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.addr_sel = ADDR_ZERO;
                state_d        = S_POP_L;
              end
            end
            FUNC_REMOVE: begin
              if (sts_i.empty) begin
                cmd_o.res_ld     = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              cmd_o.res_ld = 1'b1;
            end
          endcase
        end
      end
      S_POP_L: begin
        cmd_o.val_ld   = 1'b1;
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_LAST;
        state_d        = S_POP_W;
      end
      S_POP_W: begin
        cmd_o.mem_wr        = 1'b1;
        cmd_o.addr_sel      = ADDR_ZERO;
        cmd_o.wr_from_rdata = 1'b1;
        cmd_o.cnt_dec       = 1'b1;
        cmd_o.res_ld        = 1'b1;
        cmd_o.res_val       = 1'b1;
        state_d             = S_IDLE;
      end
      S_SCAN: begin
        if (cmp_vld_q && sts_i.match) begin
          cmd_o.hit_ld = 1'b1;
          state_d      = S_RM_L;
        end else if (cmp_vld_q && sts_i.scan_end) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_NOTFOUND;
          state_d          = S_IDLE;
        end else begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = ADDR_SCAN;
          cmd_o.scan_inc = 1'b1;
          cmp_vld_d      = 1'b1;
        end
      end
      S_RM_L: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_LAST;
        state_d        = S_RM_W;
      end
      S_RM_W: begin
        cmd_o.mem_wr        = 1'b1;
        cmd_o.addr_sel      = ADDR_HIT;
        cmd_o.wr_from_rdata = 1'b1;
        cmd_o.cnt_dec       = 1'b1;
        cmd_o.res_ld        = 1'b1;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: sv/uip_dpath.sv
// ----------------------------------------------------------------------------
// uip_dpath
// Datapath for the unordered id pool: the id memory with its single port,
// the count of held ids, the scan pointer and the result register.
// ----------------------------------------------------------------------------
module uip_dpath import uip_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] id_i,
  input  uip_cmd_t    cmd_i,
  output uip_sts_t    sts_o,
  output uip_rsp_t    rsp_o,
  output logic        done_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [31:0]     mem [CAPACITY];
  logic [31:0]     rdata_q;
  logic [31:0]     id_q;
  logic [31:0]     val_q;
  logic [31:0]     wdata;
  logic [AW-1:0]   addr;
  logic [AW-1:0]   hit_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q;
  logic [CntW-1:0] last;
  logic [CntW-1:0] prev;
  uip_rsp_t        rsp_q;
  logic            done_q;

  assign last = count_q - CntW'(1);
  assign prev = scan_q - CntW'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_ZERO:  addr = '0;
      ADDR_LAST:  addr = last[AW-1:0];
      ADDR_SCAN:  addr = scan_q[AW-1:0];
      ADDR_COUNT: addr = count_q[AW-1:0];
      ADDR_HIT:   addr = hit_q;
      default:    addr = '0;
    endcase
  end

  assign wdata = cmd_i.wr_from_rdata ? rdata_q : id_i;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      id_q <= id_i;
    end
    if (cmd_i.val_ld) begin
      val_q <= rdata_q;
    end
    if (cmd_i.hit_ld) begin
      hit_q <= prev[AW-1:0];
    end
    if (cmd_i.res_ld) begin
      rsp_q.popped_value <= cmd_i.res_val ? val_q : 32'd0;
      rsp_q.status       <= cmd_i.res_status;
      rsp_q.entry_count  <= 7'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.res_ld;
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + CntW'(1);
      end
    end
  end

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CntW'(CAPACITY));
  assign sts_o.match    = (rdata_q == id_q);
  assign sts_o.scan_end = (scan_q == count_q);

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule
